// ----- hdl/ibm_pkg.sv -----
// Shared constants, types and widths for the IoU best-match search block.
package ibm_pkg;

	// Candidate list limit and coordinate width.
	localparam int MAX_CANDIDATES = 64;
	localparam int COORD_BITS     = 16;

	// Threshold register: width and value after reset (0.6 in units of 1/256).
	localparam int THR_W     = 9;
	localparam int THR_RESET = 154;

	// Result index width.
	localparam int IDX_W = 6;

	// Derived widths.
	localparam int CNT_W   = $clog2(MAX_CANDIDATES + 1);
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int AREA_W  = 2 * DIFF_W;
	localparam int INTER_W = 2 * COORD_BITS;
	localparam int HALF_W  = COORD_BITS + 1;
	localparam int BU_W    = 2 * HALF_W;
	localparam int UNI_W   = BU_W + 1;
	localparam int A_W     = UNI_W;
	localparam int B_W     = COORD_BITS + 2;
	localparam int P_W     = A_W + B_W;
	localparam int ACC_W   = 4 * COORD_BITS + 4;

	// Op codes on the box channel.
	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_CAND  = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
	} box_t;

	// Clamped overlap extents of two boxes.
	typedef struct packed {
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
	} ovl_t;

	// Operand pair for the shared multiplier.
	typedef struct packed {
		logic signed [A_W-1:0] a;
		logic signed [B_W-1:0] b;
	} mul_req_t;

endpackage

// ----- hdl/ibm_if.sv -----
// Handshake interfaces for box input, result output and threshold write.
interface ibm_box_if;
	import ibm_pkg::*;
	logic   valid;
	logic   ready;
	logic   op;
	coord_t left;
	coord_t top;
	coord_t right;
	coord_t bottom;
	logic   last;
	modport source(output valid, op, left, top, right, bottom, last, input ready);
	modport sink(input valid, op, left, top, right, bottom, last, output ready);
endinterface

interface ibm_res_if;
	import ibm_pkg::*;
	logic             valid;
	logic             ready;
	logic             found;
	logic [IDX_W-1:0] match_index;
	logic             overflowed;
	modport source(output valid, found, match_index, overflowed, input ready);
	modport sink(input valid, found, match_index, overflowed, output ready);
endinterface

interface ibm_cfg_if;
	import ibm_pkg::*;
	logic             valid;
	logic             ready;
	logic [THR_W-1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ----- hdl/ibm_mul.sv -----
// Shared signed multiplier with a registered product.
module ibm_mul (
	input  logic                              clk,
	input  ibm_pkg::mul_req_t                 req,
	output logic signed [ibm_pkg::P_W-1:0]    prod
);
	import ibm_pkg::*;

	// One product per cycle, available the cycle after the operands.
	always_ff @(posedge clk) begin
		prod <= P_W'(req.a) * P_W'(req.b);
	end

endmodule

// ----- hdl/ibm_overlap.sv -----
// Registered intersection extents of the candidate and query boxes.
module ibm_overlap (
	input  logic          clk,
	input  ibm_pkg::box_t cand,
	input  ibm_pkg::box_t query,
	output ibm_pkg::ovl_t ovl
);
	import ibm_pkg::*;

	coord_t                   x1, y1, x2, y2;
	logic signed [DIFF_W-1:0] dw, dh;

	// Inner edges of the two boxes and their distances.
	always_comb begin
		x1 = (cand.left > query.left) ? cand.left : query.left;
		y1 = (cand.top > query.top) ? cand.top : query.top;
		x2 = (cand.right < query.right) ? cand.right : query.right;
		y2 = (cand.bottom < query.bottom) ? cand.bottom : query.bottom;
		dw = DIFF_W'(x2) - DIFF_W'(x1);
		dh = DIFF_W'(y2) - DIFF_W'(y1);
	end

	// A negative or zero extent means no overlap on that axis.
	always_ff @(posedge clk) begin
		ovl.w <= (dw > 0) ? dw[COORD_BITS-1:0] : '0;
		ovl.h <= (dh > 0) ? dh[COORD_BITS-1:0] : '0;
	end

endmodule

// ----- hdl/iou_best_match_search.sv -----
// IoU best-match search: sequencer and datapath around one shared multiplier.
// A query item is taken in the idle state; a candidate runs the overlap, product,
// union and check steps, and four cross-product steps on the multiplier when its IoU
// must be compared with the best so far. An item with last set adds the threshold
// product and a compare step before the result beat. One item is in work at a time.
// Reset (arst_n low) clears the query box, the search state and loads threshold 154.
module iou_best_match_search (
	input  logic      clk,
	input  logic      arst_n,
	ibm_box_if.sink   box,
	ibm_cfg_if.sink   cfg,
	ibm_res_if.source result
);
	import ibm_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_OVL  = 4'd1;
	localparam logic [3:0] ST_MI   = 4'd2;
	localparam logic [3:0] ST_AC   = 4'd3;
	localparam logic [3:0] ST_AQ   = 4'd4;
	localparam logic [3:0] ST_UNI  = 4'd5;
	localparam logic [3:0] ST_CHK  = 4'd6;
	localparam logic [3:0] ST_X0   = 4'd7;
	localparam logic [3:0] ST_X1   = 4'd8;
	localparam logic [3:0] ST_X2   = 4'd9;
	localparam logic [3:0] ST_X3   = 4'd10;
	localparam logic [3:0] ST_X4   = 4'd11;
	localparam logic [3:0] ST_THR  = 4'd12;
	localparam logic [3:0] ST_CMP  = 4'd13;

	logic [3:0]                state_q;
	box_t                      query_q;
	box_t                      cand_q;
	logic                      last_q;
	logic [THR_W-1:0]          thr_q;
	logic [INTER_W-1:0]        bi_q;
	logic [BU_W-1:0]           bu_q;
	logic [CNT_W-1:0]          best_pos_q;
	logic                      have_best_q;
	logic [CNT_W-1:0]          cand_count_q;
	logic                      ovf_q;
	logic [INTER_W-1:0]        inter_q;
	logic signed [AREA_W-1:0]  areac_q;
	logic signed [UNI_W-1:0]   uni_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      res_valid_q;
	logic                      res_found_q;
	logic [IDX_W-1:0]          res_idx_q;
	logic                      res_ovf_q;

	ovl_t                      ovl;
	mul_req_t                  mreq;
	logic signed [P_W-1:0]     prod;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   prod_sh;
	logic signed [ACC_W-1:0]   cross_diff;
	logic signed [DIFF_W-1:0]  cand_dx, cand_dy, qry_dx, qry_dy;
	logic signed [UNI_W-1:0]   uni_next;
	logic                      box_beat;
	logic                      res_free;
	logic                      found_next;

	ibm_overlap u_overlap (
		.clk   (clk),
		.cand  (cand_q),
		.query (query_q),
		.ovl   (ovl)
	);

	ibm_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	assign box.ready = (state_q == ST_IDLE);
	assign box_beat  = box.valid && box.ready;
	assign cfg.ready = 1'b1;
	assign res_free  = !res_valid_q || result.ready;

	assign result.valid       = res_valid_q;
	assign result.found       = res_found_q;
	assign result.match_index = res_idx_q;
	assign result.overflowed  = res_ovf_q;

	// Box widths and heights, and the running sums of the datapath.
	always_comb begin
		cand_dx    = DIFF_W'(cand_q.right) - DIFF_W'(cand_q.left);
		cand_dy    = DIFF_W'(cand_q.bottom) - DIFF_W'(cand_q.top);
		qry_dx     = DIFF_W'(query_q.right) - DIFF_W'(query_q.left);
		qry_dy     = DIFF_W'(query_q.bottom) - DIFF_W'(query_q.top);
		prod_ext   = ACC_W'(prod);
		prod_sh    = prod_ext <<< HALF_W;
		cross_diff = acc_q - prod_sh;
		uni_next   = UNI_W'(areac_q) + UNI_W'($signed(prod[AREA_W-1:0])) - UNI_W'(inter_q);
		found_next = have_best_q &&
			({{(P_W - INTER_W - 8){1'b0}}, bi_q, 8'd0} >= prod);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mreq.a = '0;
		mreq.b = '0;
		case (state_q)
			ST_MI: begin
				mreq.a = A_W'(ovl.w);
				mreq.b = B_W'(ovl.h);
			end
			ST_AC: begin
				mreq.a = A_W'(cand_dx);
				mreq.b = B_W'(cand_dy);
			end
			ST_AQ: begin
				mreq.a = A_W'(qry_dx);
				mreq.b = B_W'(qry_dy);
			end
			ST_X0: begin
				mreq.a = A_W'(inter_q);
				mreq.b = B_W'(bu_q[HALF_W-1:0]);
			end
			ST_X1: begin
				mreq.a = A_W'(inter_q);
				mreq.b = B_W'(bu_q[BU_W-1:HALF_W]);
			end
			ST_X2: begin
				mreq.a = A_W'(bi_q);
				mreq.b = B_W'(uni_q[HALF_W-1:0]);
			end
			ST_X3: begin
				mreq.a = A_W'(bi_q);
				mreq.b = B_W'(uni_q[BU_W-1:HALF_W]);
			end
			// The threshold product is held while the compare step waits for the output.
			ST_THR, ST_CMP: begin
				mreq.a = A_W'(bu_q);
				mreq.b = B_W'(thr_q);
			end
			default: begin
				mreq.a = '0;
				mreq.b = '0;
			end
		endcase
	end

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(THR_RESET);
		end else if (cfg.valid && cfg.ready) begin
			thr_q <= cfg.data;
		end
	end

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		if (box_beat) begin
			cand_q.left   <= box.left;
			cand_q.top    <= box.top;
			cand_q.right  <= box.right;
			cand_q.bottom <= box.bottom;
			last_q        <= box.last;
		end
		case (state_q)
			ST_AC:  inter_q <= prod[INTER_W-1:0];
			ST_AQ:  areac_q <= $signed(prod[AREA_W-1:0]);
			ST_UNI: uni_q   <= uni_next;
			ST_X1:  acc_q   <= prod_ext;
			ST_X2:  acc_q   <= acc_q + prod_sh;
			ST_X3:  acc_q   <= acc_q - prod_ext;
			default: begin
			end
		endcase
	end

	// Sequencer, search state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			query_q      <= '0;
			bi_q         <= '0;
			bu_q         <= BU_W'(1);
			best_pos_q   <= '0;
			have_best_q  <= 1'b0;
			cand_count_q <= '0;
			ovf_q        <= 1'b0;
			res_valid_q  <= 1'b0;
			res_found_q  <= 1'b0;
			res_idx_q    <= '0;
			res_ovf_q    <= 1'b0;
		end else begin
			// The result register is reloaded by the compare step or emptied by a beat.
			if (state_q == ST_CMP && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (box_beat) begin
						if (box.op == OP_QUERY) begin
							query_q.left   <= box.left;
							query_q.top    <= box.top;
							query_q.right  <= box.right;
							query_q.bottom <= box.bottom;
							bi_q           <= '0;
							bu_q           <= BU_W'(1);
							best_pos_q     <= '0;
							have_best_q    <= 1'b0;
							cand_count_q   <= '0;
							ovf_q          <= 1'b0;
							state_q        <= box.last ? ST_THR : ST_IDLE;
						end else if (cand_count_q >= CNT_W'(MAX_CANDIDATES)) begin
							ovf_q   <= 1'b1;
							state_q <= box.last ? ST_THR : ST_IDLE;
						end else begin
							state_q <= ST_OVL;
						end
					end
				end
				ST_OVL: state_q <= ST_MI;
				ST_MI:  state_q <= ST_AC;
				ST_AC:  state_q <= ST_AQ;
				ST_AQ:  state_q <= ST_UNI;
				ST_UNI: state_q <= ST_CHK;
				// Only a positive union and a nonzero intersection can win.
				ST_CHK: begin
					if (!uni_q[UNI_W-1] && uni_q != '0 && inter_q != '0) begin
						state_q <= ST_X0;
					end else begin
						cand_count_q <= cand_count_q + 1'b1;
						state_q      <= last_q ? ST_THR : ST_IDLE;
					end
				end
				ST_X0: state_q <= ST_X1;
				ST_X1: state_q <= ST_X2;
				ST_X2: state_q <= ST_X3;
				ST_X3: state_q <= ST_X4;
				// The candidate wins only on a strictly greater cross product.
				ST_X4: begin
					if (cross_diff > 0) begin
						bi_q        <= inter_q;
						bu_q        <= uni_q[BU_W-1:0];
						best_pos_q  <= cand_count_q;
						have_best_q <= 1'b1;
					end
					cand_count_q <= cand_count_q + 1'b1;
					state_q      <= last_q ? ST_THR : ST_IDLE;
				end
				ST_THR: state_q <= ST_CMP;
				// Load the result once the output register is free, then start over.
				ST_CMP: begin
					if (res_free) begin
						res_found_q  <= found_next;
						res_idx_q    <= found_next ? IDX_W'(best_pos_q) : '0;
						res_ovf_q    <= ovf_q;
						bi_q         <= '0;
						bu_q         <= BU_W'(1);
						best_pos_q   <= '0;
						have_best_q  <= 1'b0;
						cand_count_q <= '0;
						ovf_q        <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A new result beat appears only out of the final compare step.
	a_res_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_CMP))
		else $error("result raised outside the compare step");

	// The candidate count never passes the list limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cand_count_q <= CNT_W'(MAX_CANDIDATES))
		else $error("candidate count beyond limit");

	// A held best always has a nonzero intersection and union.
	a_best_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		have_best_q |-> (bi_q != '0 && bu_q != '0))
		else $error("best candidate with empty area");

	// A query beat restarts the search.
	a_query_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(box_beat && box.op == OP_QUERY) |=> (cand_count_q == '0 && !have_best_q && !ovf_q))
		else $error("query did not clear the search");

endmodule

// ----- dv/iou_best_match_search_checker.sv -----
// Checker for the IoU best-match search: predicts each verdict beat and compares it.
`timescale 1ns / 1ps
module iou_best_match_search_checker (
	input  logic clk,
	input  logic arst_n,
	ibm_box_if   box,
	ibm_cfg_if   cfg,
	ibm_res_if   result,
	output int   fail_count,
	output int   outstanding,
	output int   checked_cnt,
	output int   match_cnt
);
	import ibm_pkg::*;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] match_index;
		logic             overflowed;
	} verdict_t;

	// Predicted search state and threshold register.
	box_t             query_box;
	logic [63:0]      best_inter;
	logic [63:0]      best_union;
	int               best_pos;
	int               cand_cnt;
	logic             have_best;
	logic             ovf_seen;
	logic [THR_W-1:0] threshold;

	verdict_t verdicts_q[$];
	int       fails;
	int       n_checked;
	int       n_matched;

	function automatic void restart_search();
		best_inter = '0;
		best_union = 64'd1;
		best_pos   = 0;
		have_best  = 1'b0;
		cand_cnt   = 0;
		ovf_seen   = 1'b0;
	endfunction

	// Fold one accepted box beat into the search; queue a verdict when it ends the list.
	function automatic void score_box(logic op, box_t b, logic lst);
		longint       bl, bt, br, bb, ql, qt, qr, qb;
		longint       x1, y1, x2, y2, w, h, inter, area_c, area_q, uni;
		logic [127:0] lhs, rhs;
		logic         hit;
		verdict_t     v;
		if (op == OP_QUERY) begin
			query_box = b;
			restart_search();
		end else if (cand_cnt >= MAX_CANDIDATES) begin
			ovf_seen = 1'b1;
		end else begin
			bl = longint'(b.left);
			bt = longint'(b.top);
			br = longint'(b.right);
			bb = longint'(b.bottom);
			ql = longint'(query_box.left);
			qt = longint'(query_box.top);
			qr = longint'(query_box.right);
			qb = longint'(query_box.bottom);
			x1 = (bl > ql) ? bl : ql;
			y1 = (bt > qt) ? bt : qt;
			x2 = (br < qr) ? br : qr;
			y2 = (bb < qb) ? bb : qb;
			w = (x2 - x1 > 0) ? x2 - x1 : 0;
			h = (y2 - y1 > 0) ? y2 - y1 : 0;
			inter  = w * h;
			area_c = (br - bl) * (bb - bt);
			area_q = (qr - ql) * (qb - qt);
			uni    = area_c + area_q - inter;
			// Strictly greater IoU by cross-multiplication; ties keep the earlier one.
			if (uni > 0 && inter > 0) begin
				lhs = {64'd0, inter} * {64'd0, best_union};
				rhs = {64'd0, best_inter} * {64'd0, uni};
				if (lhs > rhs) begin
					best_inter = inter;
					best_union = uni;
					best_pos   = cand_cnt;
					have_best  = 1'b1;
				end
			end
			cand_cnt++;
		end
		if (lst) begin
			lhs = {64'd0, best_inter} << 8;
			rhs = {119'd0, threshold} * {64'd0, best_union};
			hit = have_best && (lhs >= rhs);
			v.found       = hit;
			v.match_index = hit ? best_pos[IDX_W-1:0] : '0;
			v.overflowed  = ovf_seen;
			verdicts_q.insert(verdicts_q.size(), v);
			restart_search();
		end
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Track beats on all three channels; outputs move by nonblocking update only.
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			query_box = '0;
			restart_search();
			threshold = THR_W'(THR_RESET);
			verdicts_q.delete();
			fails     = 0;
			n_checked = 0;
			n_matched = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				threshold = cfg.data;
			if (box.valid && box.ready)
				score_box(box.op, box_t'{box.left, box.top, box.right, box.bottom}, box.last);
			if (result.valid && result.ready) begin
				if (verdicts_q.size() == 0) begin
					fails++;
					$display("%0t: result beat with none expected, actual found %0d index %0d overflowed %0d",
						$time, result.found, result.match_index, result.overflowed);
				end else begin
					want = verdicts_q[0];
					verdicts_q.delete(0);
					n_checked++;
					if (want.found)
						n_matched++;
					check_field("found", want.found, result.found);
					check_field("match_index", want.match_index, result.match_index);
					check_field("overflowed", want.overflowed, result.overflowed);
				end
			end
		end
		fail_count  <= fails;
		outstanding <= verdicts_q.size();
		checked_cnt <= n_checked;
		match_cnt   <= n_matched;
	end

endmodule

// ----- dv/iou_best_match_search_tb.sv -----
// Testbench top for the IoU best-match search: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module iou_best_match_search_tb;
	import ibm_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int TARGET_ITEMS  = 1350;
	localparam int NUM_PHASES    = 5;
	localparam int SETTLE_CYCLES = 32;
	localparam int LONG_HOLD     = 400;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   checked_cnt;
	int   match_cnt;
	int   cycle_cnt;
	int   beats_sent;
	int   lists_sent;
	int   thr_writes;
	int   overflow_lists;
	int   rx_hold;
	bit   tx_gaps;
	bit   rx_gaps;
	box_t cur_query;

	ibm_box_if box_ch();
	ibm_cfg_if cfg_ch();
	ibm_res_if res_ch();

	iou_best_match_search u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.box    (box_ch),
		.cfg    (cfg_ch),
		.result (res_ch)
	);

	iou_best_match_search_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.box         (box_ch),
		.cfg         (cfg_ch),
		.result      (res_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked_cnt (checked_cnt),
		.match_cnt   (match_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("iou_best_match_search regression: fail");
			$finish;
		end
	end

	// Result receiver: random stall bursts, plus a long hold-off when one is requested.
	initial begin
		forever begin
			if (rx_hold > 0) begin
				res_ch.ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic box_t mk(int l, int t, int r, int b);
		box_t v;
		v.left   = coord_t'(l);
		v.top    = coord_t'(t);
		v.right  = coord_t'(r);
		v.bottom = coord_t'(b);
		return v;
	endfunction

	function automatic int jitter(int span);
		int m;
		m = (span < 1) ? 1 : span;
		return int'($urandom_range(0, 2 * m)) - m;
	endfunction

	function automatic box_t any_box();
		return mk($urandom, $urandom, $urandom, $urandom);
	endfunction

	function automatic box_t random_query();
		int x, y, w, h;
		x = int'($urandom_range(0, 40000)) - 20000;
		y = int'($urandom_range(0, 40000)) - 20000;
		if ($urandom_range(0, 3) == 0) begin
			w = $urandom_range(1, 32);
			h = $urandom_range(1, 32);
		end else begin
			w = $urandom_range(16, 4000);
			h = $urandom_range(16, 4000);
		end
		return mk(x, y, x + w, y + h);
	endfunction

	// Candidates are mostly jittered copies of the current query, so IoU lands near the threshold.
	function automatic box_t random_candidate();
		int   k, s, w, h;
		box_t c;
		k = $urandom_range(0, 99);
		w = int'(cur_query.right) - int'(cur_query.left);
		h = int'(cur_query.bottom) - int'(cur_query.top);
		if (w < 0)
			w = -w;
		if (h < 0)
			h = -h;
		s = (k < 45) ? 10 : 3;
		c = mk(int'(cur_query.left) + jitter(w / s), int'(cur_query.top) + jitter(h / s),
			int'(cur_query.right) + jitter(w / s), int'(cur_query.bottom) + jitter(h / s));
		if (k >= 70 && k < 78) begin
			c = cur_query;
		end else if (k >= 78 && k < 84) begin
			c = mk(c.right, c.bottom, c.left, c.top);
		end else if (k >= 84 && k < 92) begin
			c = any_box();
		end else if (k >= 92) begin
			c.right = c.left;
		end
		return c;
	endfunction

	// Offer one box beat, with a random idle burst ahead of it.
	task automatic send_beat(logic op, box_t b, logic lst);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			box_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		box_ch.valid  <= 1'b1;
		box_ch.op     <= op;
		box_ch.left   <= b.left;
		box_ch.top    <= b.top;
		box_ch.right  <= b.right;
		box_ch.bottom <= b.bottom;
		box_ch.last   <= lst;
		do @(posedge clk); while (!box_ch.ready);
		beats_sent++;
		if (op == OP_QUERY)
			cur_query = b;
	endtask

	// Stop offering boxes and wait until every predicted verdict has arrived.
	task automatic drain();
		box_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] value);
		drain();
		// A candidate without last may still be in work after the final verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		thr_writes++;
	endtask

	// One random list: mostly query plus candidates, some empty lists, noise and reused queries.
	task automatic run_random_list();
		int kind, n, i;
		kind = $urandom_range(0, 99);
		lists_sent++;
		if (kind < 12) begin
			send_beat(OP_QUERY, random_query(), 1'b1);
		end else if (kind < 22) begin
			send_beat($urandom_range(0, 1) ? OP_CAND : OP_QUERY, any_box(),
				1'($urandom_range(0, 1)));
		end else begin
			if (kind < 88)
				send_beat(OP_QUERY, random_query(), 1'b0);
			if ($urandom_range(0, 49) == 0)
				n = $urandom_range(MAX_CANDIDATES - 1, MAX_CANDIDATES + 6);
			else
				n = $urandom_range(1, 8);
			if (n > MAX_CANDIDATES)
				overflow_lists++;
			for (i = 0; i < n; i++)
				send_beat(OP_CAND, random_candidate(), i == n - 1);
		end
	endtask

	initial begin
		int p, goal;
		bit paused;
		arst_n        <= 1'b0;
		box_ch.valid  <= 1'b0;
		box_ch.op     <= OP_QUERY;
		box_ch.left   <= '0;
		box_ch.top    <= '0;
		box_ch.right  <= '0;
		box_ch.bottom <= '0;
		box_ch.last   <= 1'b0;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.data   <= '0;
		cur_query = '0;
		paused    = 1'b0;
		tx_gaps   = 1'b1;
		rx_gaps   = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset threshold: candidate before any query meets a zero box.
		send_beat(OP_CAND, mk(0, 0, 256, 256), 1'b1);
		send_beat(OP_QUERY, mk(0, 0, 160, 160), 1'b0);
		send_beat(OP_CAND, mk(0, 0, 160, 160), 1'b1);
		// Empty list, then candidates against the kept query: inverted, zero width, a tie.
		send_beat(OP_QUERY, mk(0, 0, 160, 160), 1'b1);
		send_beat(OP_CAND, mk(160, 160, 0, 0), 1'b0);
		send_beat(OP_CAND, mk(40, 0, 40, 160), 1'b0);
		send_beat(OP_CAND, mk(0, 0, 160, 160), 1'b0);
		send_beat(OP_CAND, mk(0, 0, 160, 160), 1'b1);
		// Overlap of one third stays below the threshold.
		send_beat(OP_CAND, mk(80, 0, 240, 160), 1'b1);
		// Extreme coordinates, inverted and full-range.
		send_beat(OP_QUERY, mk(-32768, -32768, 32767, 32767), 1'b0);
		send_beat(OP_CAND, mk(32767, 32767, -32768, -32768), 1'b0);
		send_beat(OP_CAND, mk(-32768, -32768, 32767, 32767), 1'b1);
		// Degenerate query with a half-inverted candidate gives a negative union.
		send_beat(OP_QUERY, mk(50, 50, 50, 50), 1'b0);
		send_beat(OP_CAND, mk(100, 0, 0, 100), 1'b1);
		// Zero threshold: touching edges still fail, a sliver of overlap matches.
		write_threshold(THR_W'(0));
		send_beat(OP_QUERY, mk(0, 0, 160, 160), 1'b0);
		send_beat(OP_CAND, mk(160, 0, 320, 160), 1'b0);
		send_beat(OP_CAND, mk(159, 159, 320, 320), 1'b1);
		// Thresholds of exactly one, just above one, and the register maximum.
		write_threshold(THR_W'(256));
		send_beat(OP_CAND, mk(0, 0, 160, 160), 1'b1);
		write_threshold(THR_W'(257));
		send_beat(OP_CAND, mk(0, 0, 160, 160), 1'b1);
		write_threshold(THR_W'(511));
		send_beat(OP_CAND, mk(0, 0, 160, 160), 1'b1);

		// Random phases, each at its own threshold; the last one runs without idling.
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: write_threshold(THR_W'(154));
				1: write_threshold(THR_W'(0));
				2: write_threshold(THR_W'(256));
				3: write_threshold(THR_W'(511));
				default: write_threshold(THR_W'($urandom_range(100, 230)));
			endcase
			if (p == NUM_PHASES - 1) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end
			if (p == 1)
				rx_hold = LONG_HOLD;
			goal = beats_sent + TARGET_ITEMS / NUM_PHASES;
			while (beats_sent < goal) begin
				run_random_list();
				// Once, the sender waits for every verdict before it goes on.
				if (p == 2 && !paused && beats_sent > goal - TARGET_ITEMS / (2 * NUM_PHASES)) begin
					drain();
					paused = 1'b1;
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d box beats in %0d random lists plus directed cases, %0d overflowing lists.",
			beats_sent, lists_sent, overflow_lists);
		$display("Wrote the threshold %0d times; checked %0d verdicts, %0d of them matches.",
			thr_writes, checked_cnt, match_cnt);
		if (fail_count == 0 && outstanding == 0)
			$display("iou_best_match_search regression: pass");
		else
			$display("iou_best_match_search regression: fail");
		$finish;
	end

endmodule
